[rtl/sli_pkg.sv]
// Shared types and constants for the sorted list insert/delete block.
package sli_pkg;

	// Fixed widths of the word fields on the channels.
	localparam int ACTION_W = 1;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Defaults for the top-level parameters.
	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// Operation codes carried in the action field.
	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} action_t;

	// Status codes reported with every result word.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

[rtl/sli_in_if.sv]
// Request channel: one insert or delete word per handshake.
interface sli_in_if import sli_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

[rtl/sli_out_if.sv]
// Response channel: status, entry count and the list bounds per handshake.
interface sli_out_if import sli_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        entry_count;
	logic signed [VALUE_W-1:0] smallest;
	logic signed [VALUE_W-1:0] largest;

	modport source (output valid, status, entry_count, smallest, largest, input ready);
	modport sink (input valid, status, entry_count, smallest, largest, output ready);
endinterface

[rtl/sli_cell.sv]
// One cell of the sorted row: holds one entry and trades it with its neighbors.
module sli_cell import sli_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctrl_t                   ctrl,
	input  logic signed [DATA_WIDTH-1:0] operand,
	input  logic signed [DATA_WIDTH-1:0] left_entry,
	input  logic                         left_valid,
	input  logic                         left_ge,
	input  logic signed [DATA_WIDTH-1:0] right_entry,
	input  logic                         right_valid,
	output logic signed [DATA_WIDTH-1:0] entry,
	output logic                         valid,
	output logic                         ge,
	output logic                         eq
);

	logic signed [DATA_WIDTH-1:0] entry_q;
	logic                         valid_q;

	// An empty cell counts as holding a value above every operand, so the
	// ge flags along the row form a thermometer that marks the insert point.
	assign ge    = !valid_q || (operand <= entry_q);
	assign eq    = valid_q && (operand == entry_q);
	assign entry = entry_q;
	assign valid = valid_q;

	// Valid bits: insert grows the row by one, delete pulls from the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | left_valid;
		end else if (ctrl.del && ge) begin
			valid_q <= right_valid;
		end
	end

	// Entry data: the first cell at or above the operand takes it, the cells
	// behind it take their left neighbor; on delete they take the right one.
	always_ff @(posedge clk) begin
		if (ctrl.ins && ge && !left_ge) begin
			entry_q <= operand;
		end else if (ctrl.ins && ge && left_valid) begin
			entry_q <= left_entry;
		end else if (ctrl.del && ge) begin
			entry_q <= right_entry;
		end
	end

endmodule

[rtl/sorted_list_insert_delete.sv]
// Top level of the sorted list: a row of cells plus handshake and result logic.
//
//  channel | dir | fields                                   | meaning
//  req     | in  | action, value                            | insert or delete one value
//  rsp     | out | status, entry_count, smallest, largest   | one result word per request
//
// Each request word is applied to the whole cell row in parallel, so a word
// is taken every cycle as long as the result words are taken as fast.
// The cycle is set by the compare in each cell and the match OR across the row.
// The request side holds off while a result word waits to be taken.
// Reset empties the list at once; no clearing pass is needed.
module sorted_list_insert_delete import sli_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input logic clk,
	input logic arst_n,
	sli_in_if.sink   req,
	sli_out_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [DATA_WIDTH-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]          valids;
	logic [CAPACITY-1:0]          ges;
	logic [CAPACITY-1:0]          eqs;
	logic signed [DATA_WIDTH-1:0] operand;
	cell_ctrl_t                   ctrl;
	logic                         accept;
	logic                         is_insert;
	logic                         full;
	logic                         empty;
	logic                         found;
	status_t                      status_d;
	status_t                      status_q;
	logic [CNT_W-1:0]             count_q;
	logic                         rsp_valid_q;
	logic signed [DATA_WIDTH-1:0] largest_d;

	assign operand   = DATA_WIDTH'(req.value);
	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign is_insert = (action_t'(req.action) == ACT_INSERT);
	assign full      = valids[CAPACITY-1];
	assign empty     = !valids[0];
	assign found     = |eqs;

	// Row of cells, each wired to its two neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] l_entry;
		logic                         l_valid;
		logic                         l_ge;
		logic signed [DATA_WIDTH-1:0] r_entry;
		logic                         r_valid;

		if (i == 0) begin : g_head
			assign l_entry = '0;
			assign l_valid = 1'b1;
			assign l_ge    = 1'b0;
		end else begin : g_body
			assign l_entry = entries[i-1];
			assign l_valid = valids[i-1];
			assign l_ge    = ges[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_entry = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_entry = entries[i+1];
			assign r_valid = valids[i+1];
		end

		sli_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.operand    (operand),
			.left_entry (l_entry),
			.left_valid (l_valid),
			.left_ge    (l_ge),
			.right_entry(r_entry),
			.right_valid(r_valid),
			.entry      (entries[i]),
			.valid      (valids[i]),
			.ge         (ges[i]),
			.eq         (eqs[i])
		);
	end

	// Command decode and status for the word being accepted.
	always_comb begin
		ctrl.ins = accept && is_insert && !full;
		ctrl.del = accept && !is_insert && found;
		if (is_insert && full) begin
			status_d = ST_FULL;
		end else if (!is_insert && empty) begin
			status_d = ST_EMPTY;
		end else if (!is_insert && !found) begin
			status_d = ST_NOT_FOUND;
		end else begin
			status_d = ST_OK;
		end
	end

	// Result register and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.del) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// The largest entry sits in the last valid cell of the row.
	always_comb begin
		largest_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (valids[i] && (i == CAPACITY - 1 || !valids[(i + 1) % CAPACITY])) begin
				largest_d = largest_d | entries[i];
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = COUNT_W'(count_q);
	assign rsp.smallest    = valids[0] ? VALUE_W'(entries[0]) : '0;
	assign rsp.largest     = VALUE_W'(largest_d);

	// The count register always matches the number of occupied cells.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == 32'(count_q))
		else $error("entry count disagrees with occupied cells");

	// Occupied cells always form a contiguous run from the head of the row.
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valids >> 1) & ~valids) == '0)
		else $error("occupied cells are not packed at the head");

	// A full report is only given when every cell was occupied.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d == ST_FULL |=> count_q == CNT_W'(CAPACITY))
		else $error("full status with free cells");

	// An accepted word always leaves a result word pending.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted word produced no result");

endmodule

[sim/sorted_list_checker.sv]
// Checker for the sorted list: predicts every result word and compares it field by field.
`timescale 1ns / 1ps

module sorted_list_checker import sli_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	sli_in_if   req,
	sli_out_if  rsp,
	output int  mismatches,
	output int  results_due
);

	// One predicted result word.
	typedef struct {
		status_t                   status;
		logic [COUNT_W-1:0]        entry_count;
		logic signed [VALUE_W-1:0] smallest;
		logic signed [VALUE_W-1:0] largest;
	} list_result_t;

	// Shadow copy of the stored list, kept in ascending order.
	logic signed [VALUE_W-1:0] list_vals [CAPACITY];
	int                        list_len;
	list_result_t              due_results[$];

	// Applies one insert or delete to the shadow list and returns the result word.
	function automatic list_result_t list_apply(input action_t op,
			input logic signed [VALUE_W-1:0] v);
		list_result_t r;
		int pos;
		r.status = ST_OK;
		if (op == ACT_INSERT) begin
			if (list_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// The new value goes ahead of any equal values.
				pos = 0;
				while (pos < list_len && v > list_vals[pos])
					pos++;
				for (int i = list_len; i > pos; i--)
					list_vals[i] = list_vals[i-1];
				list_vals[pos] = v;
				list_len++;
			end
		end else begin
			if (list_len == 0) begin
				r.status = ST_EMPTY;
			end else begin
				pos = 0;
				while (pos < list_len && list_vals[pos] != v)
					pos++;
				if (pos >= list_len) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
		end
		r.entry_count = COUNT_W'(list_len);
		if (list_len == 0) begin
			r.smallest = '0;
			r.largest  = '0;
		end else begin
			r.smallest = list_vals[0];
			r.largest  = list_vals[list_len-1];
		end
		return r;
	endfunction

	// Requests are predicted before results are matched, so a word taken in the
	// same cycle as its request still finds its expectation.
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			due_results.delete();
			mismatches = 0;
			results_due = 0;
		end else begin
			if (req.valid && req.ready)
				due_results.push_back(list_apply(action_t'(req.action), req.value));
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result word taken with no request outstanding");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp.entry_count);
						mismatches++;
					end
					if (rsp.smallest !== want.smallest) begin
						$error("smallest: expected %0d, got %0d", want.smallest, rsp.smallest);
						mismatches++;
					end
					if (rsp.largest !== want.largest) begin
						$error("largest: expected %0d, got %0d", want.largest, rsp.largest);
						mismatches++;
					end
				end
			end
			results_due = due_results.size();
		end
	end

endmodule

[sim/tb_sorted_list_insert_delete.sv]
// Testbench top for the sorted list: clock, reset, stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;
	import sli_pkg::*;

	localparam int CAPACITY       = DEF_CAPACITY;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_WORDS    = 258;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   results_due;

	// Idle and stall rates of the current phase, in percent.
	int   send_idle;
	int   stall_pct;
	logic hold_rsp;

	// Values the list should currently hold, in no particular order.
	logic signed [VALUE_W-1:0] held_vals[$];

	sli_in_if  req_ch ();
	sli_out_if rsp_ch ();

	sorted_list_insert_delete DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_list_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Small values in four picks of ten so duplicates and hits are common, an
	// extreme in one of ten, and full-range values in the rest.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return VALUE_W'(int'($urandom_range(15)) - 8);
			4: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Offers one word at a falling edge and returns at the falling edge after it is taken.
	task automatic send_word(input action_t op, input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= op;
		req_ch.value  <= v;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		@(negedge clk);
	endtask

	// Tracks the expected contents so deletes can aim at stored values.
	task automatic issue(input action_t op, input logic signed [VALUE_W-1:0] v);
		if (op == ACT_INSERT) begin
			if (held_vals.size() < CAPACITY)
				held_vals.push_back(v);
		end else begin
			for (int i = 0; i < held_vals.size(); i++) begin
				if (held_vals[i] == v) begin
					held_vals.delete(i);
					break;
				end
			end
		end
		send_word(op, v);
	endtask

	// Response side: random stalls, or one long hold-off when asked for.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Ends the run when no word moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_sorted_list_insert_delete NOT OK");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int idle_tab[4];
		int stall_tab[4];
		bit filling;
		action_t op;
		logic signed [VALUE_W-1:0] v;

		idle_tab  = '{0, 73, 0, 31};
		stall_tab = '{0, 0, 73, 31};
		send_idle = 0;
		stall_pct = 0;
		hold_rsp  = 1'b0;
		filling   = 1'b1;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = ACT_INSERT;
		req_ch.value  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: delete on an empty list, extremes, a duplicate, a missing
		// value, filling up, an insert into a full list, removing both ends.
		issue(ACT_DELETE, '0);
		issue(ACT_INSERT, VAL_MIN);
		issue(ACT_INSERT, VAL_MAX);
		issue(ACT_INSERT, '0);
		issue(ACT_INSERT, '1);
		issue(ACT_INSERT, '0);
		issue(ACT_DELETE, 32'sd5);
		issue(ACT_DELETE, '0);
		for (int i = 0; i < CAPACITY - 4; i++)
			issue(ACT_INSERT, pick_value());
		issue(ACT_INSERT, 32'sd3);
		issue(ACT_DELETE, VAL_MAX);
		issue(ACT_DELETE, VAL_MIN);

		// Random: sweep between full and empty so both ends are reached often.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 0 && n == 100)
					hold_rsp = 1'b1;
				if (held_vals.size() >= CAPACITY)
					filling = 1'b0;
				else if (held_vals.size() == 0)
					filling = 1'b1;
				op = ($urandom_range(99) < (filling ? 70 : 30)) ? ACT_INSERT : ACT_DELETE;
				if (op == ACT_DELETE && held_vals.size() > 0 && $urandom_range(3) != 0)
					v = held_vals[$urandom_range(held_vals.size() - 1)];
				else
					v = pick_value();
				issue(op, v);
			end
		end
		req_ch.valid <= 1'b0;

		// Drain the outstanding results, then a short tail.
		while (results_due != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_sorted_list_insert_delete OK");
		else
			$display("tb_sorted_list_insert_delete NOT OK");
		$finish;
	end

endmodule
